// File: rtl/strided_chunk_karatsuba_multiplier_assert.svh
// ============================================================================
// Assertion macros for the strided-chunk Karatsuba multiplier
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef STRIDED_CHUNK_KARATSUBA_MULTIPLIER_ASSERT_SVH
`define STRIDED_CHUNK_KARATSUBA_MULTIPLIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCKM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sckm_pkg.sv
// ============================================================================
// sckm_pkg
// Field widths, pipeline depth and shared types of the chunk multiplier.
// ============================================================================
package sckm_pkg;

  localparam int unsigned X_W     = 28;
  localparam int unsigned Y_W     = 30;
  localparam int unsigned P_W     = 58;
  localparam int unsigned N_STAGE = 5;

  typedef logic [X_W-1:0]     x_operand_t;
  typedef logic [Y_W-1:0]     y_operand_t;
  typedef logic [P_W-1:0]     product_t;
  typedef logic [N_STAGE-1:0] stage_vec_t;

  // Per-stage load enables produced by the pipeline control.
  typedef struct packed {
    stage_vec_t en;
  } pipe_ctl_t;

  // Least common multiple by stepping both multiples until they meet.
  function automatic int unsigned lcm(input int unsigned p, input int unsigned q);
    int unsigned mp;
    int unsigned mq;
    mp = p;
    mq = q;
    while (mp != mq) begin
      if (mp < mq) begin
        mp = mp + p;
      end else begin
        mq = mq + q;
      end
    end
    return mp;
  endfunction

endpackage

// File: rtl/sckm_if.sv
// ============================================================================
// sckm_in_if / sckm_out_if
// Valid/ready stream channels for operand pairs and products.
// ============================================================================
interface sckm_in_if;
  logic                 valid;
  logic                 ready;
  sckm_pkg::x_operand_t x_operand;
  sckm_pkg::y_operand_t y_operand;

  modport source (output valid, output x_operand, output y_operand, input ready);
  modport sink   (input valid, input x_operand, input y_operand, output ready);
endinterface

interface sckm_out_if;
  logic               valid;
  logic               ready;
  sckm_pkg::product_t product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

// File: rtl/sckm_pipe_ctrl.sv
// ============================================================================
// sckm_pipe_ctrl
// Load enables for the pipeline: a stage loads when it is empty or when the
// stage after it moves on, so bubbles are squeezed out under a stall.
// ============================================================================
module sckm_pipe_ctrl (
  input  sckm_pkg::stage_vec_t stage_valid,
  input  logic                 out_ready,
  output sckm_pkg::pipe_ctl_t  ctl
);

  always_comb begin
    ctl.en[sckm_pkg::N_STAGE-1] = !stage_valid[sckm_pkg::N_STAGE-1] || out_ready;
    for (int k = sckm_pkg::N_STAGE - 2; k >= 0; k--) begin
      ctl.en[k] = !stage_valid[k] || ctl.en[k+1];
    end
  end

endmodule

// File: rtl/strided_chunk_karatsuba_multiplier.sv
// ============================================================================
// strided_chunk_karatsuba_multiplier
// Exact product of strided operand chunks using shared Karatsuba terms.
// ============================================================================
// Accepts one operand pair per cycle while the output is not stalled. The
// stages are: chunk extraction and Karatsuba differences, the chunk
// multipliers, the Karatsuba correction and shifting of every term, a first
// adder layer over groups of four terms, and a final adder layer that is also
// the output register. Each stage holds under back-pressure only when full, so
// a stalled result still lets new pairs fill the empty stages behind it.
module strided_chunk_karatsuba_multiplier #(
  parameter int unsigned CHUNK_X_BITS = 4,
  parameter int unsigned CHUNK_Y_BITS = 6,
  parameter int unsigned ORDER        = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  sckm_in_if.sink           in_ch,
  sckm_out_if.source        out_ch
);

  localparam int unsigned S     = sckm_pkg::lcm(CHUNK_X_BITS, CHUNK_Y_BITS);
  localparam int unsigned NC    = ORDER + 1;
  localparam int unsigned NP    = ORDER * (ORDER + 1) / 2;
  localparam int unsigned NT    = NC + NP;
  localparam int unsigned NG    = (NT + 3) / 4;
  localparam int unsigned DW    = CHUNK_X_BITS + CHUNK_Y_BITS;
  localparam int unsigned MW    = DW + 2;
  localparam int unsigned KW    = DW + 1;
  localparam int unsigned KFW   = MW + 1;
  localparam int unsigned P_W   = sckm_pkg::P_W;

  sckm_pkg::stage_vec_t v_r;
  sckm_pkg::pipe_ctl_t  ctl;

  sckm_pipe_ctrl u_ctrl (
    .stage_valid (v_r),
    .out_ready   (out_ch.ready),
    .ctl         (ctl)
  );

  assign in_ch.ready  = ctl.en[0];
  assign out_ch.valid = v_r[sckm_pkg::N_STAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ctl.en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < sckm_pkg::N_STAGE; k++) begin
        if (ctl.en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 0: chunks and Karatsuba differences.
  logic        [CHUNK_X_BITS-1:0] a_nxt  [NC];
  logic        [CHUNK_Y_BITS-1:0] b_nxt  [NC];
  logic signed [CHUNK_X_BITS:0]   da_nxt [NP];
  logic signed [CHUNK_Y_BITS:0]   db_nxt [NP];
  logic        [CHUNK_X_BITS-1:0] a_r    [NC];
  logic        [CHUNK_Y_BITS-1:0] b_r    [NC];
  logic signed [CHUNK_X_BITS:0]   da_r   [NP];
  logic signed [CHUNK_Y_BITS:0]   db_r   [NP];

  always_comb begin
    logic [63:0] xw;
    logic [63:0] yw;
    int unsigned p;
    xw = 64'(in_ch.x_operand);
    yw = 64'(in_ch.y_operand);
    p  = 0;
    for (int i = 0; i < NC; i++) begin
      a_nxt[i] = CHUNK_X_BITS'(xw >> (i * S));
      b_nxt[i] = CHUNK_Y_BITS'(yw >> (i * S));
    end
    for (int i = 1; i < NC; i++) begin
      for (int j = 0; j < i; j++) begin
        da_nxt[p] = $signed({1'b0, a_nxt[j]}) - $signed({1'b0, a_nxt[i]});
        db_nxt[p] = $signed({1'b0, b_nxt[i]}) - $signed({1'b0, b_nxt[j]});
        p = p + 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      da_r <= da_nxt;
      db_r <= db_nxt;
    end
  end

  // Stage 1: diagonal products and one signed product per chunk pair.
  logic        [DW-1:0] diag_r [NC];
  logic signed [MW-1:0] kp_r   [NP];

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      for (int i = 0; i < NC; i++) begin
        diag_r[i] <= DW'(a_r[i]) * DW'(b_r[i]);
      end
      for (int p = 0; p < NP; p++) begin
        kp_r[p] <= MW'(da_r[p]) * MW'(db_r[p]);
      end
    end
  end

  // Stage 2: the diagonal products complete each pair's cross sum, then every
  // term is placed at its weight. Weights beyond the product width drop out.
  logic [P_W-1:0] term_nxt [NT];
  logic [P_W-1:0] term_r   [NT];
  logic           k_ovf;

  always_comb begin
    logic [KFW-1:0] k_full;
    int unsigned    p;
    p     = 0;
    k_ovf = 1'b0;
    for (int i = 0; i < NC; i++) begin
      term_nxt[i] = P_W'(diag_r[i]) << (2 * i * S);
    end
    for (int i = 1; i < NC; i++) begin
      for (int j = 0; j < i; j++) begin
        k_full = {kp_r[p][MW-1], kp_r[p]} + KFW'(diag_r[j]) + KFW'(diag_r[i]);
        k_ovf  = k_ovf | (k_full[KFW-1:KW] != '0);
        term_nxt[NC+p] = P_W'(k_full[KW-1:0]) << ((i + j) * S);
        p = p + 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      term_r <= term_nxt;
    end
  end

  // Stage 3: first adder layer, up to four terms per group.
  logic [P_W-1:0] psum_nxt [NG];
  logic [P_W-1:0] psum_r   [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      psum_nxt[g] = '0;
      for (int t = 0; t < 4; t++) begin
        if (g * 4 + t < NT) begin
          psum_nxt[g] = psum_nxt[g] + term_r[g*4+t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      psum_r <= psum_nxt;
    end
  end

  // Stage 4: final adder layer into the output register.
  logic [P_W-1:0] product_nxt;
  logic [P_W-1:0] product_r;

  always_comb begin
    product_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      product_nxt = product_nxt + psum_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      product_r <= product_nxt;
    end
  end

  assign out_ch.product = product_r;

  `include "strided_chunk_karatsuba_multiplier_assert.svh"

  `SCKM_ASSERT_NEXT(a_accept_fills_stage0, in_ch.valid && in_ch.ready, v_r[0],
                    "accepted pair did not enter the first stage")
  `SCKM_ASSERT_SAME(a_cross_sum_fits, v_r[1], !k_ovf,
                    "Karatsuba cross sum is negative or too wide")
  `SCKM_ASSERT_SAME(a_ready_needs_bubble, out_ch.valid && !out_ch.ready && in_ch.ready,
                    !(&v_r), "input ready while stalled pipeline is full")

endmodule

// File: sim/tb_strided_chunk_karatsuba_multiplier.sv
// ============================================================================
// tb_strided_chunk_karatsuba_multiplier
// Self-checking testbench for the strided-chunk Karatsuba multiplier. Operand
// pairs go in through the input stream, and every product is compared with a
// value worked out here from the strided chunks. Directed corner cases come
// first. Random pairs follow with bursts of idling on both sides, one long
// output stall, one full drain, and a final stretch at full rate.
// ============================================================================
module tb_strided_chunk_karatsuba_multiplier;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHUNK_X_BITS   = 4;
  localparam int unsigned CHUNK_Y_BITS   = 6;
  localparam int unsigned ORDER          = 2;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned LONG_HOLD      = 150;

  // The chunk stride is the least common multiple of the two chunk widths.
  function automatic int unsigned chunk_stride(input int unsigned p, input int unsigned q);
    int unsigned g;
    int unsigned r;
    int unsigned t;
    g = p;
    r = q;
    while (r != 0) begin
      t = g % r;
      g = r;
      r = t;
    end
    return (p / g) * q;
  endfunction

  localparam int unsigned STRIDE = chunk_stride(CHUNK_X_BITS, CHUNK_Y_BITS);

  logic clk;
  logic rst_n;

  sckm_in_if  in_if ();
  sckm_out_if out_if ();

  strided_chunk_karatsuba_multiplier #(
    .CHUNK_X_BITS (CHUNK_X_BITS),
    .CHUNK_Y_BITS (CHUNK_Y_BITS),
    .ORDER        (ORDER)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  sckm_pkg::product_t expected_products[$];
  sckm_pkg::product_t product_want;
  int unsigned        mismatch_count = 0;
  int unsigned        idle_cycles = 0;
  bit                 src_gaps_on;
  bit                 sink_stalls_on;
  int unsigned        sink_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bits covered by chunk idx of a chunk of the given width.
  function automatic logic [63:0] chunk_field(input int unsigned width, input int unsigned idx);
    logic [63:0] ones;
    ones = (64'd1 << width) - 64'd1;
    return ones << (idx * STRIDE);
  endfunction

  // Sum of every chunk pair product at its weight, kept to 64 bits.
  function automatic sckm_pkg::product_t predict_product(input sckm_pkg::x_operand_t x,
                                                         input sckm_pkg::y_operand_t y);
    logic [63:0] acc;
    logic [63:0] a_chunk;
    logic [63:0] b_chunk;
    int unsigned i;
    int unsigned j;
    acc = '0;
    for (i = 0; i <= ORDER; i++) begin
      for (j = 0; j <= ORDER; j++) begin
        a_chunk = (64'(x) >> (i * STRIDE)) & ((64'd1 << CHUNK_X_BITS) - 64'd1);
        b_chunk = (64'(y) >> (j * STRIDE)) & ((64'd1 << CHUNK_Y_BITS) - 64'd1);
        acc = acc + ((a_chunk * b_chunk) << ((i + j) * STRIDE));
      end
    end
    return sckm_pkg::product_t'(acc);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Called at a clock edge; returns at the edge where the pair is transferred.
  task automatic send_operands(input sckm_pkg::x_operand_t x, input sckm_pkg::y_operand_t y);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.x_operand <= x;
    in_if.y_operand <= y;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
  endtask

  task automatic pick_operands(output sckm_pkg::x_operand_t x,
                               output sckm_pkg::y_operand_t y);
    int unsigned kind;
    int unsigned i;
    kind = $urandom_range(0, 9);
    x = sckm_pkg::x_operand_t'($urandom);
    y = sckm_pkg::y_operand_t'($urandom);
    if (kind >= 8) begin
      x = $urandom_range(0, 1) ? '1 : '0;
      y = $urandom_range(0, 1) ? '1 : '0;
    end
    // Push individual chunks to their extremes, leaving the gap bits as they are.
    if (kind >= 5) begin
      for (i = 0; i <= ORDER; i++) begin
        case ($urandom_range(0, 2))
          0: x = x & ~sckm_pkg::x_operand_t'(chunk_field(CHUNK_X_BITS, i));
          1: x = x | sckm_pkg::x_operand_t'(chunk_field(CHUNK_X_BITS, i));
          default: ;
        endcase
        case ($urandom_range(0, 2))
          0: y = y & ~sckm_pkg::y_operand_t'(chunk_field(CHUNK_Y_BITS, i));
          1: y = y | sckm_pkg::y_operand_t'(chunk_field(CHUNK_Y_BITS, i));
          default: ;
        endcase
      end
    end
  endtask

  task automatic send_random(input int unsigned count);
    sckm_pkg::x_operand_t x;
    sckm_pkg::y_operand_t y;
    repeat (count) begin
      pick_operands(x, y);
      send_operands(x, y);
    end
  endtask

  // At least one edge passes first, so the last pair sent has been queued.
  task automatic wait_for_drain();
    do begin
      @(posedge clk);
    end while (expected_products.size() != 0);
  endtask

  task automatic test_directed();
    sckm_pkg::x_operand_t x_chunks;
    sckm_pkg::y_operand_t y_chunks;
    int unsigned i;
    int unsigned j;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    x_chunks = '0;
    y_chunks = '0;
    for (i = 0; i <= ORDER; i++) begin
      x_chunks = x_chunks | sckm_pkg::x_operand_t'(chunk_field(CHUNK_X_BITS, i));
      y_chunks = y_chunks | sckm_pkg::y_operand_t'(chunk_field(CHUNK_Y_BITS, i));
    end
    send_operands('0, '0);
    send_operands('1, '1);
    send_operands('1, '0);
    send_operands('0, '1);
    // Only the bits between chunks are set, so the product must be zero.
    send_operands(~x_chunks, ~y_chunks);
    send_operands(~x_chunks, '1);
    for (i = 0; i <= ORDER; i++) begin
      for (j = 0; j <= ORDER; j++) begin
        send_operands(sckm_pkg::x_operand_t'(chunk_field(CHUNK_X_BITS, i)),
                      sckm_pkg::y_operand_t'(chunk_field(CHUNK_Y_BITS, j)));
      end
    end
    send_operands(sckm_pkg::x_operand_t'(1), sckm_pkg::y_operand_t'(1));
    send_operands(sckm_pkg::x_operand_t'(1) << (sckm_pkg::X_W - 1),
                  sckm_pkg::y_operand_t'(1) << (sckm_pkg::Y_W - 1));
    send_operands({(sckm_pkg::X_W / 2){2'b10}}, {(sckm_pkg::Y_W / 2){2'b01}});
    send_operands({(sckm_pkg::X_W / 2){2'b01}}, {(sckm_pkg::Y_W / 2){2'b10}});
  endtask

  task automatic test_random_idling();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    send_random(450);
  endtask

  // The receiver holds off long enough for the pipeline to fill and refuse
  // further pairs, while the sender keeps offering at full rate.
  task automatic test_output_backpressure();
    src_gaps_on      = 1'b0;
    sink_stalls_on   = 1'b0;
    sink_hold_cycles = LONG_HOLD;
    send_random(80);
  endtask

  task automatic test_drain_and_resume();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    send_random(50);
    in_if.valid <= 1'b0;
    wait_for_drain();
    send_random(50);
  endtask

  task automatic test_full_rate();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_random(300);
  endtask

  initial begin : result_sink
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (sink_hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
        out_if.ready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Predict on every input transfer and check every output transfer in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        expected_products.push_back(predict_product(in_if.x_operand, in_if.y_operand));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_products.size() == 0) begin
          report_error($sformatf("product 0x%0h arrived with none expected", out_if.product));
        end else begin
          product_want = expected_products.pop_front();
          if (out_if.product !== product_want) begin
            report_error($sformatf("product 0x%0h, expected 0x%0h",
                                   out_if.product, product_want));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR %0t ns: no transfer for %0d cycles", $time, idle_cycles);
        $display("strided_chunk_karatsuba_multiplier verification failed");
        $finish;
      end
    end
  end

  initial begin
    src_gaps_on      = 1'b0;
    sink_stalls_on   = 1'b0;
    sink_hold_cycles = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.x_operand <= '0;
    in_if.y_operand <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_idling();
    test_output_backpressure();
    test_drain_and_resume();
    test_full_rate();

    in_if.valid <= 1'b0;
    wait_for_drain();
    repeat (2 * sckm_pkg::N_STAGE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("strided_chunk_karatsuba_multiplier verification clean");
    end else begin
      $display("strided_chunk_karatsuba_multiplier verification failed");
    end
    $finish;
  end

endmodule

// File: strided_chunk_karatsuba_multiplier.f
+incdir+rtl
rtl/sckm_pkg.sv
rtl/sckm_if.sv
rtl/sckm_pipe_ctrl.sv
rtl/strided_chunk_karatsuba_multiplier.sv
sim/tb_strided_chunk_karatsuba_multiplier.sv
